// ===== src/pkjs_pkg.sv =====
`timescale 1ns / 1ps
package pkjs_pkg;

   // Default sizes of the table and of the stored key.
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 16;

   // Fixed payload widths of the two channels.
   localparam int REQ_KEY_W = 16;
   localparam int RSP_KEY_W = 16;
   localparam int OCC_W     = 5;

   // Codes of the kind field of an input item.
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   // Status of one table slot, as handed to the neighbor cell.
   typedef struct packed {
      logic valid;
      logic running;
      logic pend;
   } pkjs_slot_type;

   // Prefix flags rippling from the oldest slot towards the newest.
   typedef struct packed {
      logic any;
      logic run;
      logic pend;
   } pkjs_chain_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic compare;
      logic remove;
      logic append;
      logic run_new;
      logic promote;
   } pkjs_ctrl_type;

endpackage

// ===== src/pkjs_req_if.sv =====
`timescale 1ns / 1ps
interface pkjs_req_if;
   import pkjs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [REQ_KEY_W-1:0] key;

   modport source (output valid, output kind, output key, input ready);
   modport sink   (input valid, input kind, input key, output ready);
endinterface

// ===== src/pkjs_rsp_if.sv =====
`timescale 1ns / 1ps
interface pkjs_rsp_if;
   import pkjs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 start_res;
   logic [RSP_KEY_W-1:0] start_key;
   logic                 removed;
   logic                 dropped;
   logic [OCC_W-1:0]     occupancy;

   modport source (output valid, output start_res, output start_key, output removed,
                   output dropped, output occupancy, input ready);
   modport sink   (input valid, input start_res, input start_key, input removed,
                   input dropped, input occupancy, output ready);
endinterface

// ===== src/per_key_job_serializer_top.sv =====
`timescale 1ns / 1ps
// Per-key job serializer.
// The req channel carries one item per event: kind selects an arrival or the
// completion of a running job, key names the event type. The rsp channel gives
// exactly one item per accepted request: whether a job starts and its key,
// whether a completion removed a running entry, whether an arrival was dropped
// on a full table, and the number of entries held afterwards.
// The table is a row of cells, slot 0 the oldest. Each cell compares its key
// in parallel; the oldest-match flags ripple through the row, and removal
// closes the gap by letting each cell at or above the removed one copy its
// neighbor. An item's result reaches the output register through compare at
// the accepting edge, then remove or append, promote, and result load. The
// next item is taken in the cycle after the result is loaded, so a new item
// is not accepted before the last one is through. When the receiver stalls,
// the result waits in the output register and the block holds the following
// item at its result stage.
// Reset is synchronous and empties the table; no clearing pass is needed.
module per_key_job_serializer_top #(
   parameter int TABLE_DEPTH = pkjs_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = pkjs_pkg::KEY_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   pkjs_req_if.sink  req_if,
   pkjs_rsp_if.source rsp_if
);
   import pkjs_pkg::*;

   localparam int KeyW = (KEY_BITS < REQ_KEY_W) ? KEY_BITS : REQ_KEY_W;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_REMOVE, S_PROMOTE, S_OUT} state_type;

   state_type           state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [KeyW-1:0]     key_ff, key_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                start_ff, start_in;
   logic                removed_ff, removed_in;
   logic                dropped_ff, dropped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_start_ff, rsp_start_in;
   logic [RSP_KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic                rsp_removed_ff, rsp_removed_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                accept;
   logic                full;
   logic [KeyW-1:0]     cmd_key;
   pkjs_ctrl_type       ctrl;
   pkjs_slot_type       cell_slot [TABLE_DEPTH];
   logic [KeyW-1:0]     cell_key  [TABLE_DEPTH];
   pkjs_chain_type      chain     [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] valid_vec;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == CntW'(TABLE_DEPTH));
   assign cmd_key      = (state_ff == S_IDLE) ? KeyW'(req_if.key) : key_ff;

   // Commands to the cell row for the current step of the item.
   assign ctrl.compare = accept;
   assign ctrl.remove  = (state_ff == S_REMOVE) && (kind_ff == KIND_DONE);
   assign ctrl.append  = (state_ff == S_REMOVE) && (kind_ff == KIND_ARRIVAL) && !full;
   assign ctrl.run_new = !chain[TABLE_DEPTH].any;
   assign ctrl.promote = (state_ff == S_PROMOTE) && (kind_ff == KIND_DONE);

   assign chain[0] = '0;

   // The row of table cells, oldest entry in cell 0.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      pkjs_slot_type   up_slot;
      logic [KeyW-1:0] up_key;
      logic            low_valid;

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign up_slot = '0;
         assign up_key  = '0;
      end else begin : g_mid
         assign up_slot = cell_slot[i+1];
         assign up_key  = cell_key[i+1];
      end

      if (i == 0) begin : g_first
         assign low_valid = 1'b1;
      end else begin : g_rest
         assign low_valid = cell_slot[i-1].valid;
      end

      pkjs_cell #(
         .KEY_W (KeyW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .cmd_key   (cmd_key),
         .up_slot   (up_slot),
         .up_key    (up_key),
         .low_valid (low_valid),
         .chain_lo  (chain[i]),
         .slot_out  (cell_slot[i]),
         .key_out   (cell_key[i]),
         .chain_hi  (chain[i+1])
      );

      assign valid_vec[i] = cell_slot[i].valid;
   end

   // Sequencer and result register.
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      start_in       = start_ff;
      removed_in     = removed_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_start_in   = rsp_start_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_occ_in     = rsp_occ_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_if.kind;
               key_in   = KeyW'(req_if.key);
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (kind_ff == KIND_ARRIVAL) begin
               removed_in = 1'b0;
               dropped_in = full;
               start_in   = !full && !chain[TABLE_DEPTH].any;
               if (!full) begin
                  count_in = count_ff + CntW'(1);
               end
            end else begin
               removed_in = chain[TABLE_DEPTH].run;
               dropped_in = 1'b0;
               start_in   = 1'b0;
               if (chain[TABLE_DEPTH].run) begin
                  count_in = count_ff - CntW'(1);
               end
            end
            state_in = S_PROMOTE;
         end
         S_PROMOTE: begin
            if (kind_ff == KIND_DONE) begin
               start_in = chain[TABLE_DEPTH].pend;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_start_in   = start_ff;
               rsp_key_in     = start_ff ? RSP_KEY_W'(key_ff) : '0;
               rsp_removed_in = removed_ff;
               rsp_dropped_in = dropped_ff;
               rsp_occ_in     = OCC_W'(count_ff);
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      start_ff       <= start_in;
      removed_ff     <= removed_in;
      dropped_ff     <= dropped_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.start_res = rsp_start_ff;
   assign rsp_if.start_key = rsp_key_ff;
   assign rsp_if.removed   = rsp_removed_ff;
   assign rsp_if.dropped   = rsp_dropped_ff;
   assign rsp_if.occupancy = rsp_occ_ff;

   // The entry count always matches the number of occupied cells.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      CntW'($countones(valid_vec)) == count_ff)
      else $error("entry count differs from occupied cells");

   // The count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // An accepted item always moves on to the remove step.
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_REMOVE)
      else $error("accepted item did not advance");

   // A dropped arrival never starts a job, and never removes an entry.
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dropped_ff |-> !rsp_start_ff && !rsp_removed_ff)
      else $error("dropped item reports start or removal");

   // Cells stay packed: a free cell is never below an occupied one.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + TABLE_DEPTH'(1)) & valid_vec) == '0)
      else $error("table entries are not packed");

endmodule

// ===== src/pkjs_cell.sv =====
`timescale 1ns / 1ps
module pkjs_cell #(
   parameter int KEY_W = pkjs_pkg::KEY_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pkjs_pkg::pkjs_ctrl_type  ctrl,
   input  logic [KEY_W-1:0]        cmd_key,
   input  pkjs_pkg::pkjs_slot_type  up_slot,
   input  logic [KEY_W-1:0]        up_key,
   input  logic                    low_valid,
   input  pkjs_pkg::pkjs_chain_type chain_lo,
   output pkjs_pkg::pkjs_slot_type  slot_out,
   output logic [KEY_W-1:0]        key_out,
   output pkjs_pkg::pkjs_chain_type chain_hi
);
   import pkjs_pkg::*;

   pkjs_slot_type    slot_ff, slot_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             hit_any_ff, hit_any_in;
   logic             hit_run_ff, hit_run_in;
   logic             hit;

   assign hit      = slot_ff.valid && (key_ff == cmd_key);
   assign slot_out = slot_ff;
   assign key_out  = key_ff;

   // Prefix flags: this slot or any older one holds a match of each sort.
   assign chain_hi.any  = chain_lo.any  | hit_any_ff;
   assign chain_hi.run  = chain_lo.run  | hit_run_ff;
   assign chain_hi.pend = chain_lo.pend | slot_ff.pend;

   // One step of the item on this slot, chosen by the sequencer's command.
   always_comb begin
      slot_in    = slot_ff;
      key_in     = key_ff;
      hit_any_in = hit_any_ff;
      hit_run_in = hit_run_ff;
      priority if (ctrl.compare) begin
         hit_any_in   = hit;
         hit_run_in   = hit && slot_ff.running;
         slot_in.pend = hit && !slot_ff.running;
      end else if (ctrl.remove && (chain_lo.run || hit_run_ff)) begin
         // At or above the removed entry every slot takes its newer neighbor.
         slot_in    = up_slot;
         key_in     = up_key;
         hit_any_in = 1'b0;
         hit_run_in = 1'b0;
      end else if (ctrl.append && !slot_ff.valid && low_valid) begin
         // The first free slot receives the arrival.
         slot_in.valid   = 1'b1;
         slot_in.running = ctrl.run_new;
         slot_in.pend    = 1'b0;
         key_in          = cmd_key;
      end else if (ctrl.promote) begin
         if (slot_ff.pend && !chain_lo.pend) begin
            slot_in.running = 1'b1;
         end
         slot_in.pend = 1'b0;
      end else begin
         // No command for this slot: it holds its state.
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         hit_any_ff <= 1'b0;
         hit_run_ff <= 1'b0;
      end else begin
         slot_ff    <= slot_in;
         hit_any_ff <= hit_any_in;
         hit_run_ff <= hit_run_in;
      end
      key_ff <= key_in;
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import pkjs_pkg::*;

   localparam int TABLE_SLOTS   = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 1725;
   localparam int POOL_SIZE     = 6;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 20;

   // One result item as the block reports it.
   typedef struct packed {
      logic                 start_res;
      logic [RSP_KEY_W-1:0] start_key;
      logic                 removed;
      logic                 dropped;
      logic [OCC_W-1:0]     occupancy;
   } job_result_type;

   // One row of the directed stimulus.
   typedef struct packed {
      logic                 kind;
      logic [REQ_KEY_W-1:0] key;
      logic                 typed;
      job_result_type       res;
   } job_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pkjs_req_if req_ch ();
   pkjs_rsp_if rsp_ch ();

   per_key_job_serializer_top #(
      .TABLE_DEPTH(TABLE_DEPTH_DEF),
      .KEY_BITS(KEY_BITS_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Shadow copy of the job table, packed at the low slots, oldest first.
   logic [REQ_KEY_W-1:0] held_key [TABLE_SLOTS];
   bit                   held_run [TABLE_SLOTS];
   int                   held_count = 0;

   job_result_type       expected_results[$];
   job_row_type          directed_rows[$];
   logic [REQ_KEY_W-1:0] key_pool [POOL_SIZE];
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;
   bit                   idle_on = 1'b1;

   always #5 clock = ~clock;

   // Computes the result of one item and updates the shadow table.
   function automatic job_result_type model_job_table(input logic kind,
                                                      input logic [REQ_KEY_W-1:0] key);
      job_result_type r;
      bit             hit;
      bit             done;
      int             i;
      int             j;
      r = '0;
      if (kind == KIND_ARRIVAL) begin
         hit = 1'b0;
         for (i = 0; i < held_count; i++)
            if (held_key[i] == key) hit = 1'b1;
         if (held_count >= TABLE_SLOTS) begin
            r.dropped = 1'b1;
         end else begin
            held_key[held_count] = key;
            held_run[held_count] = !hit;
            held_count++;
            if (!hit) begin
               r.start_res = 1'b1;
               r.start_key = key;
            end
         end
      end else begin
         // Remove the oldest running entry of the key and close the gap.
         done = 1'b0;
         for (i = 0; i < held_count && !done; i++) begin
            if (held_run[i] && held_key[i] == key) begin
               for (j = i; j < held_count - 1; j++) begin
                  held_key[j] = held_key[j + 1];
                  held_run[j] = held_run[j + 1];
               end
               held_count--;
               held_run[held_count] = 1'b0;
               r.removed = 1'b1;
               done = 1'b1;
            end
         end
         // Promote the oldest pending entry of the key, removal or not.
         done = 1'b0;
         for (i = 0; i < held_count && !done; i++) begin
            if (!held_run[i] && held_key[i] == key) begin
               held_run[i] = 1'b1;
               r.start_res = 1'b1;
               r.start_key = key;
               done = 1'b1;
            end
         end
      end
      r.occupancy = held_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic job_result_type make_result(input logic start_res,
                                                  input logic [RSP_KEY_W-1:0] start_key,
                                                  input logic removed, input logic dropped,
                                                  input int occupancy);
      job_result_type r;
      r.start_res = start_res;
      r.start_key = start_key;
      r.removed   = removed;
      r.dropped   = dropped;
      r.occupancy = occupancy[OCC_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input logic kind, input logic [REQ_KEY_W-1:0] key,
                                   input logic typed, input job_result_type res);
      job_row_type row;
      row.kind  = kind;
      row.key   = key;
      row.typed = typed;
      row.res   = res;
      directed_rows.push_back(row);
   endfunction

   // Gap lengths: mostly none or short, a few long, none in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Keys mostly come from a small pool so that they collide in the table.
   function automatic logic [REQ_KEY_W-1:0] pick_key();
      logic [REQ_KEY_W-1:0] k;
      if ($urandom_range(0, 99) < 75) begin
         k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Drives one item, waits for its acceptance and records its expectation.
   task automatic send_item(input logic kind, input logic [REQ_KEY_W-1:0] key,
                            input logic typed, input job_result_type typed_res);
      job_result_type predicted;
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.key   <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = model_job_table(kind, key);
      expected_results.push_back(typed ? typed_res : predicted);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds the sender off until every expected item has come back.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Result checker: each accepted item against the oldest expectation.
   always @(posedge clock) begin : check_results
      job_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result item: start_res %0d start_key 0x%0h occupancy %0d",
                   rsp_ch.start_res, rsp_ch.start_key, rsp_ch.occupancy);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("start_res", want.start_res, rsp_ch.start_res);
            compare_field("start_key", want.start_key, rsp_ch.start_key);
            compare_field("removed", want.removed, rsp_ch.removed);
            compare_field("dropped", want.dropped, rsp_ch.dropped);
            compare_field("occupancy", want.occupancy, rsp_ch.occupancy);
         end
      end
   end

   // Cycles without any accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Result receiver with random stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
         @(posedge clock);
      end
   end

   // Stimulus: directed rows, then random traffic, then the final verdict.
   initial begin
      job_row_type          row;
      logic                 kind;
      logic [REQ_KEY_W-1:0] key;
      bit                   filling;
      int                   n;
      int                   i;

      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_ARRIVAL;
      req_ch.key   <= '0;
      reset        <= 1'b1;

      // Empty table, extreme keys, a pending arrival, removal with and
      // without promotion, and a completion of an unknown key.
      add_row(KIND_DONE,    16'h0000, 1'b1, make_result(0, 16'h0000, 0, 0, 0));
      add_row(KIND_ARRIVAL, 16'h0000, 1'b1, make_result(1, 16'h0000, 0, 0, 1));
      add_row(KIND_ARRIVAL, 16'hFFFF, 1'b1, make_result(1, 16'hFFFF, 0, 0, 2));
      add_row(KIND_ARRIVAL, 16'h0000, 1'b1, make_result(0, 16'h0000, 0, 0, 3));
      add_row(KIND_DONE,    16'hFFFF, 1'b1, make_result(0, 16'h0000, 1, 0, 2));
      add_row(KIND_DONE,    16'h0000, 1'b1, make_result(1, 16'h0000, 1, 0, 1));
      add_row(KIND_DONE,    16'h1234, 1'b1, make_result(0, 16'h0000, 0, 0, 1));
      // Fill the table with a mix of new and repeated keys.
      add_row(KIND_ARRIVAL, 16'h8000, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h0001, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h8000, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h5555, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'hAAAA, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h0001, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h00FF, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'hFF00, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h8000, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h0F0F, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'hF0F0, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h5555, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h7FFF, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h0002, 1'b0, '0);
      add_row(KIND_ARRIVAL, 16'h1234, 1'b0, '0);
      // A full table drops arrivals whether or not their key is held.
      add_row(KIND_ARRIVAL, 16'h0000, 1'b1, make_result(0, 16'h0000, 0, 1, 16));
      add_row(KIND_ARRIVAL, 16'h7777, 1'b1, make_result(0, 16'h0000, 0, 1, 16));
      add_row(KIND_DONE,    16'h8000, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         send_item(row.kind, row.key, row.typed, row.res);
         pause_sender(pick_gap());
      end
      wait_for_drain();

      // Random traffic that swings the table between empty and full.
      filling = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 250 == 0)
            for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
         if (n == 800)
            wait_for_drain();
         idle_on = ((n / 150) % 5) != 2;

         if (held_count == 0)
            filling = 1'b1;
         else if (held_count >= TABLE_SLOTS && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if ($urandom_range(0, 99) < 2)
            filling = !filling;

         if ($urandom_range(0, 99) < (filling ? 75 : 25))
            kind = KIND_ARRIVAL;
         else
            kind = KIND_DONE;

         // Completions mostly name a key that the table holds.
         if (kind == KIND_DONE && held_count > 0 && $urandom_range(0, 99) < 70)
            key = held_key[$urandom_range(0, held_count - 1)];
         else
            key = pick_key();

         send_item(kind, key, 1'b0, '0);
         pause_sender(pick_gap());
      end

      idle_on = 1'b1;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
